/* src/asdm_pkg.sv */
// Package for the analog stick deadband mapper.
// Holds field widths, the output scale, register indexes and pipeline types.
// No dependencies.
`default_nettype none

package asdm_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned QUO_W      = 10;
  localparam int unsigned PROD_W     = 26;
  localparam int unsigned FULL_SCALE = 1000;

  typedef enum logic [1:0] {
    REG_CENTER = 2'd0,
    REG_START  = 2'd1,
    REG_END    = 2'd2,
    REG_DEAD   = 2'd3
  } reg_index_t;

  // Side information that travels with an item alongside the divider.
  typedef struct packed {
    logic zero;
    logic full;
    logic neg;
  } side_t;

endpackage

`default_nettype wire

/* src/analog_stick_deadband_mapper.sv */
// Top level of the analog stick deadband mapper: APB register file,
// deadband and endpoint stages, constant multiply, one-bit-per-stage divider.
// Depends on asdm_pkg.
// One transaction is accepted per cycle while sample_stall is low.
// The divider takes ten stages, one quotient bit each.
// A two-entry output buffer lets the pipeline keep accepting while a result waits.
// Reset is synchronous and active high; it clears all valid bits and loads the
// register defaults (center 2048, start 0, end 4095, deadband 0).
`default_nettype none

module analog_stick_deadband_mapper
  import asdm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ADDR_W-1:0]          paddr,
  input  wire logic [DATA_W-1:0]          pwdata,
  output logic      [DATA_W-1:0]          prdata,
  output logic                            pready,
  input  wire logic                       sample_valid,
  output logic                            sample_stall,
  input  wire logic [SAMPLE_W-1:0]        raw_sample,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic signed [POS_W-1:0]         position
);

  localparam int unsigned NPIPE = 5 + QUO_W;

  logic [SAMPLE_W-1:0] center_value;
  logic [SAMPLE_W-1:0] start_value;
  logic [SAMPLE_W-1:0] end_value;
  logic [SAMPLE_W-1:0] dead_width;
  reg_index_t          reg_index;

  logic [NPIPE-1:0] v;
  logic             en;
  logic             skid_valid;
  logic [POS_W-1:0] skid;
  logic [POS_W-1:0] pos_calc;
  logic [POS_W-1:0] mag;

  logic [SAMPLE_W:0]   rc;
  logic                s1_below;
  logic                s1_order;
  logic [SAMPLE_W-1:0] s1_diff;
  logic [SAMPLE_W-1:0] s1_xp;
  logic [SAMPLE_W-1:0] s1_xm;
  logic [SAMPLE_W-1:0] s1_sp;
  logic [SAMPLE_W-1:0] s1_sm;
  logic [SAMPLE_W-1:0] s1_ep;
  logic [SAMPLE_W-1:0] s1_em;

  logic                s2_dead;
  logic                s2_neg;
  logic [SAMPLE_W-1:0] s2_x;
  logic [SAMPLE_W-1:0] s2_f;

  logic                s3_dead;
  logic                s3_neg;
  logic [SAMPLE_W:0]   s3_sx;
  logic [SAMPLE_W:0]   s3_sf;

  logic                s4_full_zone;
  logic                s4_c_zone;
  logic                s4_zero;
  logic [SAMPLE_W:0]   s4_mx;
  logic [SAMPLE_W:0]   s4_df;
  side_t               s4_side;
  logic [SAMPLE_W-1:0] s4_m;
  logic [SAMPLE_W-1:0] s4_den;

  logic [PROD_W-1:0]   drem [0:QUO_W];
  logic [QUO_W-1:0]    dquo [0:QUO_W];
  logic [SAMPLE_W-1:0] dden [0:QUO_W];
  side_t               dside [0:QUO_W];

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_value <= SAMPLE_W'(2048);
      start_value  <= '0;
      end_value    <= SAMPLE_W'(4095);
      dead_width   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_CENTER: center_value <= pwdata[SAMPLE_W-1:0];
        REG_START:  start_value  <= pwdata[SAMPLE_W-1:0];
        REG_END:    end_value    <= pwdata[SAMPLE_W-1:0];
        REG_DEAD:   dead_width   <= pwdata[SAMPLE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_CENTER: prdata = DATA_W'(center_value);
      REG_START:  prdata = DATA_W'(start_value);
      REG_END:    prdata = DATA_W'(end_value);
      REG_DEAD:   prdata = DATA_W'(dead_width);
      default:    prdata = '0;
    endcase
  end

  // The whole pipeline moves together; it halts only when the output buffer is full.
  assign en           = !skid_valid;
  assign sample_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NPIPE-2:0], sample_valid};
    end
  end

  // Stage 1: distance from center and all deadband shifts.
  assign rc = {1'b0, raw_sample} - {1'b0, center_value};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_below <= rc[SAMPLE_W];
      s1_diff  <= rc[SAMPLE_W] ? (SAMPLE_W'(0) - rc[SAMPLE_W-1:0]) : rc[SAMPLE_W-1:0];
      s1_order <= start_value < end_value;
      s1_xp    <= raw_sample + dead_width;
      s1_xm    <= raw_sample - dead_width;
      s1_sp    <= start_value + dead_width;
      s1_sm    <= start_value - dead_width;
      s1_ep    <= end_value + dead_width;
      s1_em    <= end_value - dead_width;
    end
  end

  // Stage 2: deadband test and selection of the moved sample and far endpoint.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_dead <= s1_diff < dead_width;
      s2_neg  <= !(s1_below ^ s1_order);
      s2_x    <= s1_below ? s1_xp : s1_xm;
      case ({s1_below, s1_order})
        2'b11:   s2_f <= s1_sp;
        2'b01:   s2_f <= s1_em;
        2'b10:   s2_f <= s1_ep;
        default: s2_f <= s1_sm;
      endcase
    end
  end

  // Stage 3: offsets of the sample and the far endpoint from the center.
  always_ff @(posedge clk) begin
    if (en) begin
      s3_dead <= s2_dead;
      s3_neg  <= s2_neg;
      s3_sx   <= {1'b0, s2_x} - {1'b0, center_value};
      s3_sf   <= {1'b0, s2_f} - {1'b0, center_value};
    end
  end

  // Stage 4: clamp zones and magnitudes.
  always_comb begin
    if (s3_sf[SAMPLE_W]) begin
      s4_full_zone = $signed(s3_sx) <= $signed(s3_sf);
      s4_c_zone    = !s3_sx[SAMPLE_W];
    end else begin
      s4_full_zone = $signed(s3_sx) >= $signed(s3_sf);
      s4_c_zone    = s3_sx[SAMPLE_W] || (s3_sx == '0);
    end
    s4_zero = s3_dead || (s3_sf == '0) || s4_c_zone;
    s4_mx   = s3_sx[SAMPLE_W] ? ((SAMPLE_W+1)'(0) - s3_sx) : s3_sx;
    s4_df   = s3_sf[SAMPLE_W] ? ((SAMPLE_W+1)'(0) - s3_sf) : s3_sf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side.zero <= s4_zero;
      s4_side.full <= !s4_zero && s4_full_zone;
      s4_side.neg  <= s3_neg;
      s4_m         <= s4_mx[SAMPLE_W-1:0];
      s4_den       <= s4_df[SAMPLE_W-1:0];
    end
  end

  // Stage 5: scale the offset by the full-scale output.
  always_ff @(posedge clk) begin
    if (en) begin
      drem[0]  <= PROD_W'(s4_m) * PROD_W'(FULL_SCALE);
      dquo[0]  <= '0;
      dden[0]  <= s4_den;
      dside[0] <= s4_side;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar j = 1; j <= QUO_W; j++) begin : g_div
    logic [PROD_W-1:0] trial;
    logic              ge;

    assign trial = PROD_W'(dden[j-1]) << (QUO_W - j);
    assign ge    = drem[j-1] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        drem[j]  <= ge ? (drem[j-1] - trial) : drem[j-1];
        dquo[j]  <= dquo[j-1] | (QUO_W'(ge) << (QUO_W - j));
        dden[j]  <= dden[j-1];
        dside[j] <= dside[j-1];
      end
    end
  end

  // Final value with clamping and sign.
  always_comb begin
    if (dside[QUO_W].full) begin
      mag = POS_W'(FULL_SCALE);
    end else if (dside[QUO_W].zero) begin
      mag = '0;
    end else begin
      mag = POS_W'(dquo[QUO_W]);
    end
    pos_calc = dside[QUO_W].neg ? (POS_W'(0) - mag) : mag;
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= v[NPIPE-1];
      end
    end else if (en && v[NPIPE-1]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      position <= skid_valid ? $signed(skid) : $signed(pos_calc);
    end else if (en && v[NPIPE-1]) begin
      skid <= pos_calc;
    end
  end

  // Checks.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($signed(position) >= -11'sd1000 && $signed(position) <= 11'sd1000))
    else $error("position out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid)
    else $error("input stalled with no result pending");

  a_stall_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_stall) |-> $past(result_valid && result_stall))
    else $error("input stall raised without an output stall");

  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    (v[NPIPE-1] && !dside[QUO_W].zero && !dside[QUO_W].full)
      |-> (dquo[QUO_W] < QUO_W'(FULL_SCALE)))
    else $error("interior quotient reached full scale");

endmodule

`default_nettype wire
